### hdl/kcl_pkg.sv
// Shared types, constants and helpers for the keypad code lock.
package kcl_pkg;

    localparam int unsigned CODE_LEN   = 4;
    localparam int unsigned KEY_W      = 8;
    localparam int unsigned DIGIT_W    = 6;
    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned SCREEN_W   = 3;
    localparam int unsigned SLOT_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [KEY_W-1:0] KEY_NONE  = 8'd0;
    localparam logic [KEY_W-1:0] KEY_A     = 8'h41;
    localparam logic [KEY_W-1:0] KEY_C     = 8'h43;
    localparam logic [KEY_W-1:0] KEY_STAR  = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
    localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;
    localparam logic [KEY_W-1:0] BLANK     = 8'h20;

    localparam logic [COUNT_W-1:0] CODE_LEN_CNT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_DIGIT_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_DIGIT_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_DIGIT_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_DIGIT_3 = 3'd3;

    localparam logic [DIGIT_W-1:0] RST_CODE_DIGIT_0 = 6'd55;
    localparam logic [DIGIT_W-1:0] RST_CODE_DIGIT_1 = 6'd53;
    localparam logic [DIGIT_W-1:0] RST_CODE_DIGIT_2 = 6'd51;
    localparam logic [DIGIT_W-1:0] RST_CODE_DIGIT_3 = 6'd54;

    typedef enum logic [2:0] {
        MS_START   = 3'd0,
        MS_MAIN    = 3'd1,
        MS_OPER    = 3'd2,
        MS_BEGIN   = 3'd3,
        MS_ENTER   = 3'd4,
        MS_CORRECT = 3'd5,
        MS_WRONG   = 3'd6
    } t_menu_state;

    typedef enum logic [2:0] {
        ES_IDLE    = 3'd0,
        ES_WAIT    = 3'd1,
        ES_STORE   = 3'd2,
        ES_RELEASE = 3'd3,
        ES_COUNT   = 3'd4,
        ES_COMPARE = 3'd5,
        ES_OK      = 3'd6,
        ES_BAD     = 3'd7
    } t_entry_state;

    localparam logic [SCREEN_W-1:0] SCR_START   = 3'd0;
    localparam logic [SCREEN_W-1:0] SCR_MAIN    = 3'd1;
    localparam logic [SCREEN_W-1:0] SCR_OPER    = 3'd2;
    localparam logic [SCREEN_W-1:0] SCR_ENTER   = 3'd3;
    localparam logic [SCREEN_W-1:0] SCR_CORRECT = 3'd4;
    localparam logic [SCREEN_W-1:0] SCR_WRONG   = 3'd5;

    typedef struct packed {
        t_menu_state                   menu;
        t_entry_state                  entry;
        logic [COUNT_W-1:0]            count;
        logic [CODE_LEN-1:0][KEY_W-1:0] digits;
        logic [KEY_W-1:0]              held;
    } t_lock_state;

    typedef struct packed {
        logic [SCREEN_W-1:0] screen;
        logic [COUNT_W-1:0]  digits_entered;
    } t_result;

    function automatic logic [SCREEN_W-1:0] screen_of(input t_menu_state ms);
        logic [SCREEN_W-1:0] s;
        s = SCR_START;
        unique case (ms)
            MS_START:   s = SCR_START;
            MS_MAIN:    s = SCR_MAIN;
            MS_OPER:    s = SCR_OPER;
            MS_BEGIN,
            MS_ENTER:   s = SCR_ENTER;
            MS_CORRECT: s = SCR_CORRECT;
            MS_WRONG:   s = SCR_WRONG;
            default:    s = SCR_START;
        endcase
        return s;
    endfunction

endpackage

### hdl/kcl_step.sv
// Next-state logic of the menu and code entry machines for one keypad scan.
module kcl_step (
    input  kcl_pkg::t_lock_state                                  i_state,
    input  logic [kcl_pkg::KEY_W-1:0]                             i_key,
    input  logic [kcl_pkg::CODE_LEN-1:0][kcl_pkg::DIGIT_W-1:0]    i_code,
    output kcl_pkg::t_lock_state                                  o_state,
    output kcl_pkg::t_result                                      o_result
);

    kcl_pkg::t_menu_state  menu_nx;
    kcl_pkg::t_entry_state entry_mid;
    kcl_pkg::t_lock_state  st;
    logic                  is_digit;
    logic                  match;
    logic [kcl_pkg::COUNT_W-1:0] count_inc;

    assign is_digit  = (i_key >= kcl_pkg::KEY_ZERO) && (i_key <= kcl_pkg::KEY_NINE);
    assign count_inc = i_state.count + kcl_pkg::COUNT_W'(1);

    always_comb begin
        match = 1'b1;
        for (int i = 0; i < kcl_pkg::CODE_LEN; i++) begin
            if (i_state.digits[i] != {2'b00, i_code[i]}) begin
                match = 1'b0;
            end
        end
    end

    // Menu rule first; entry rule sees the entry state it leaves.
    always_comb begin
        menu_nx   = i_state.menu;
        entry_mid = i_state.entry;
        unique case (i_state.menu)
            kcl_pkg::MS_START: menu_nx = kcl_pkg::MS_MAIN;
            kcl_pkg::MS_MAIN: begin
                if (i_key == kcl_pkg::KEY_A) menu_nx = kcl_pkg::MS_OPER;
                if (i_key == kcl_pkg::KEY_C) menu_nx = kcl_pkg::MS_BEGIN;
            end
            kcl_pkg::MS_OPER, kcl_pkg::MS_CORRECT, kcl_pkg::MS_WRONG: begin
                if (i_key == kcl_pkg::KEY_STAR) menu_nx = kcl_pkg::MS_MAIN;
            end
            kcl_pkg::MS_BEGIN: begin
                entry_mid = kcl_pkg::ES_WAIT;
                menu_nx   = kcl_pkg::MS_ENTER;
            end
            kcl_pkg::MS_ENTER: begin
                if (i_state.entry == kcl_pkg::ES_OK)  menu_nx = kcl_pkg::MS_CORRECT;
                if (i_state.entry == kcl_pkg::ES_BAD) menu_nx = kcl_pkg::MS_WRONG;
            end
            default: menu_nx = i_state.menu;
        endcase
    end

    always_comb begin
        st       = i_state;
        st.menu  = menu_nx;
        st.entry = entry_mid;
        unique case (entry_mid)
            kcl_pkg::ES_WAIT: begin
                if (is_digit) begin
                    st.held  = i_key;
                    st.entry = kcl_pkg::ES_STORE;
                end
            end
            kcl_pkg::ES_STORE: begin
                st.digits[i_state.count[kcl_pkg::SLOT_W-1:0]] = i_state.held;
                st.entry = kcl_pkg::ES_RELEASE;
            end
            kcl_pkg::ES_RELEASE: begin
                if (i_key == kcl_pkg::KEY_NONE) st.entry = kcl_pkg::ES_COUNT;
            end
            kcl_pkg::ES_COUNT: begin
                st.count = count_inc;
                st.entry = (count_inc < kcl_pkg::CODE_LEN_CNT) ? kcl_pkg::ES_WAIT
                                                               : kcl_pkg::ES_COMPARE;
            end
            kcl_pkg::ES_COMPARE: begin
                for (int i = 0; i < kcl_pkg::CODE_LEN; i++) begin
                    st.digits[i] = kcl_pkg::BLANK;
                end
                st.count = '0;
                st.entry = match ? kcl_pkg::ES_OK : kcl_pkg::ES_BAD;
            end
            default: st.entry = entry_mid;
        endcase
    end

    assign o_state                 = st;
    assign o_result.screen         = kcl_pkg::screen_of(i_state.menu);
    assign o_result.digits_entered = st.count;

endmodule

### hdl/kcl_out_stage.sv
// Output register holding one result until the downstream side takes it.
module kcl_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  kcl_pkg::t_result i_result,
    input  logic             i_take,
    output logic             o_valid,
    output kcl_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    kcl_pkg::t_result r_result;

    assign n_valid = i_load | (r_valid & ~i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### hdl/keypad_code_lock.sv
// Top level of the four-digit keypad code lock.
// A result is registered and reaches the master side in the cycle after its scan is taken.
// Throughput: one scan per cycle; the slave side stays ready while the result
// register is empty or is being drained in the same cycle.
// Reset (i_rst_n low, synchronous): menu to start, entry idle, count zero, buffer blank,
// secret code to 7536, result register empty.
module keypad_code_lock (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kcl_pkg::DIGIT_W-1:0]      i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [kcl_pkg::KEY_W-1:0]        i_s_axis_tdata,   // [7:0] key_code
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [kcl_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata    // [2:0] screen,
                                                               // [5:3] digits_entered
);

    logic [kcl_pkg::CODE_LEN-1:0][kcl_pkg::DIGIT_W-1:0] r_code;
    kcl_pkg::t_lock_state r_state;
    kcl_pkg::t_lock_state n_state;
    kcl_pkg::t_result     step_result;
    kcl_pkg::t_result     out_result;
    logic                 accept;

    assign o_s_axis_tready = ~o_m_axis_tvalid | i_m_axis_tready;
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code[0] <= kcl_pkg::RST_CODE_DIGIT_0;
            r_code[1] <= kcl_pkg::RST_CODE_DIGIT_1;
            r_code[2] <= kcl_pkg::RST_CODE_DIGIT_2;
            r_code[3] <= kcl_pkg::RST_CODE_DIGIT_3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kcl_pkg::REG_CODE_DIGIT_0: r_code[0] <= i_cfg_data;
                kcl_pkg::REG_CODE_DIGIT_1: r_code[1] <= i_cfg_data;
                kcl_pkg::REG_CODE_DIGIT_2: r_code[2] <= i_cfg_data;
                kcl_pkg::REG_CODE_DIGIT_3: r_code[3] <= i_cfg_data;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    kcl_step u_step (
        .i_state  (r_state),
        .i_key    (i_s_axis_tdata),
        .i_code   (r_code),
        .o_state  (n_state),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.menu   <= kcl_pkg::MS_START;
            r_state.entry  <= kcl_pkg::ES_IDLE;
            r_state.count  <= '0;
            r_state.digits <= {kcl_pkg::CODE_LEN{kcl_pkg::BLANK}};
            r_state.held   <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    kcl_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (step_result),
        .i_take   (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = {2'b00, out_result.digits_entered, out_result.screen};

endmodule

### tb/keypad_code_lock_test.sv
// Self-checking testbench for the keypad code lock: directed scans, then random code entry.
module keypad_code_lock_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kcl_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int PHASES       = 8;
    localparam int PHASE_SCANS  = 170;
    localparam int DIR_ROWS     = 28;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             known;
        t_result          want;
    } t_scan_row;

    // Walk to operating and back, then one correct entry of the reset code.
    // Rows with known = 0 are checked against the lock model only.
    localparam t_scan_row [0:DIR_ROWS-1] SCAN_TABLE = '{
        '{8'hFF,            1'b1, '{SCR_START, 3'd0}},
        '{KEY_A,            1'b1, '{SCR_MAIN,  3'd0}},
        '{KEY_C,            1'b1, '{SCR_OPER,  3'd0}},
        '{KEY_STAR,         1'b1, '{SCR_OPER,  3'd0}},
        '{KEY_C,            1'b1, '{SCR_MAIN,  3'd0}},
        '{KEY_STAR,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_ZERO - 8'd1,  1'b0, '{SCR_START, 3'd0}},
        '{KEY_NINE + 8'd1,  1'b0, '{SCR_START, 3'd0}},
        '{KEY_ZERO + 8'd7,  1'b0, '{SCR_START, 3'd0}},
        '{KEY_NINE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_ZERO,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_ZERO + 8'd5,  1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_ZERO + 8'd3,  1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_ZERO + 8'd6,  1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_NONE,         1'b0, '{SCR_START, 3'd0}},
        '{KEY_STAR,         1'b0, '{SCR_START, 3'd0}}
    };

    logic                    i_clk;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_idx   = '0;
    logic [DIGIT_W-1:0]      cfg_data  = '0;
    logic                    s_valid   = 1'b0;
    logic [KEY_W-1:0]        s_data    = '0;
    logic                    m_ready   = 1'b0;
    logic                    tab_known = 1'b0;
    t_result                 tab_want  = '0;

    logic                    o_s_axis_tready;
    logic                    o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;

    // lock model state
    t_menu_state             lock_menu;
    t_entry_state            lock_entry;
    logic [COUNT_W-1:0]      lock_count;
    logic [KEY_W-1:0]        lock_slots [CODE_LEN];
    logic [KEY_W-1:0]        lock_held;
    logic [DIGIT_W-1:0]      lock_secret [CODE_LEN];

    t_result                 screens_due [$];
    int                      fail_count = 0;
    int                      cycle_count = 0;
    int                      scans_sent = 0;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;

    keypad_code_lock u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Menu rule first, then the entry rule on the entry state it left.
    function automatic t_result press_key(input logic [KEY_W-1:0] key);
        t_result r;
        logic    hit;
        int      k;
        case (lock_menu)
            MS_START:          r.screen = SCR_START;
            MS_MAIN:           r.screen = SCR_MAIN;
            MS_OPER:           r.screen = SCR_OPER;
            MS_BEGIN, MS_ENTER: r.screen = SCR_ENTER;
            MS_CORRECT:        r.screen = SCR_CORRECT;
            MS_WRONG:          r.screen = SCR_WRONG;
            default:           r.screen = SCR_START;
        endcase
        case (lock_menu)
            MS_START: lock_menu = MS_MAIN;
            MS_MAIN: begin
                if (key == KEY_A) lock_menu = MS_OPER;
                if (key == KEY_C) lock_menu = MS_BEGIN;
            end
            MS_OPER, MS_CORRECT, MS_WRONG: begin
                if (key == KEY_STAR) lock_menu = MS_MAIN;
            end
            MS_BEGIN: begin
                lock_entry = ES_WAIT;
                lock_menu  = MS_ENTER;
            end
            MS_ENTER: begin
                if (lock_entry == ES_OK)  lock_menu = MS_CORRECT;
                if (lock_entry == ES_BAD) lock_menu = MS_WRONG;
            end
            default: ;
        endcase
        case (lock_entry)
            ES_WAIT: begin
                if (key >= KEY_ZERO && key <= KEY_NINE) begin
                    lock_held  = key;
                    lock_entry = ES_STORE;
                end
            end
            ES_STORE: begin
                // the digit held at detection, not this scan's key
                lock_slots[lock_count[SLOT_W-1:0]] = lock_held;
                lock_entry = ES_RELEASE;
            end
            ES_RELEASE: begin
                if (key == KEY_NONE) lock_entry = ES_COUNT;
            end
            ES_COUNT: begin
                lock_count = lock_count + 3'd1;
                lock_entry = (lock_count < CODE_LEN_CNT) ? ES_WAIT : ES_COMPARE;
            end
            ES_COMPARE: begin
                hit = 1'b1;
                for (k = 0; k < CODE_LEN; k++) begin
                    if (lock_slots[k] != {2'b00, lock_secret[k]}) hit = 1'b0;
                    lock_slots[k] = BLANK;
                end
                lock_count = '0;
                lock_entry = hit ? ES_OK : ES_BAD;
            end
            default: ;
        endcase
        r.digits_entered = lock_count;
        return r;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        t_result guess;
        int      k;
        if (!rst_n) begin
            lock_menu  = MS_START;
            lock_entry = ES_IDLE;
            lock_count = '0;
            lock_held  = KEY_NONE;
            for (k = 0; k < CODE_LEN; k++) lock_slots[k] = BLANK;
            lock_secret[0] = RST_CODE_DIGIT_0;
            lock_secret[1] = RST_CODE_DIGIT_1;
            lock_secret[2] = RST_CODE_DIGIT_2;
            lock_secret[3] = RST_CODE_DIGIT_3;
            screens_due.delete();
        end else begin
            if (cfg_we && cfg_idx < CODE_LEN) lock_secret[cfg_idx[SLOT_W-1:0]] = cfg_data;
            if (s_valid && o_s_axis_tready) begin
                guess = press_key(s_data);
                screens_due.push_back(tab_known ? tab_want : guess);
            end
            if (o_m_axis_tvalid && m_ready) begin
                got.screen         = o_m_axis_tdata[SCREEN_W-1:0];
                got.digits_entered = o_m_axis_tdata[SCREEN_W+COUNT_W-1:SCREEN_W];
                if (screens_due.size() == 0) begin
                    $error("unexpected result: screen %0d digits %0d",
                           got.screen, got.digits_entered);
                    fail_count++;
                end else begin
                    want = screens_due.pop_front();
                    if (got.screen != want.screen) begin
                        $error("screen: expected %0d, got %0d", want.screen, got.screen);
                        fail_count++;
                    end
                    if (got.digits_entered != want.digits_entered) begin
                        $error("digits_entered: expected %0d, got %0d",
                               want.digits_entered, got.digits_entered);
                        fail_count++;
                    end
                    if (o_m_axis_tdata[OUT_DATA_W-1:SCREEN_W+COUNT_W] != '0) begin
                        $error("pad: expected 0, got %0d",
                               o_m_axis_tdata[OUT_DATA_W-1:SCREEN_W+COUNT_W]);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Call at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_key(input logic [KEY_W-1:0] key, input logic known = 1'b0,
                            input t_result want = '0);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_data  <= 8'($urandom_range(255));
            @(negedge i_clk);
        end
        s_valid   <= 1'b1;
        s_data    <= key;
        tab_known <= known;
        tab_want  <= want;
        do @(posedge i_clk); while (!o_s_axis_tready);
        scans_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (screens_due.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic load_code(input logic [DIGIT_W-1:0] d0, input logic [DIGIT_W-1:0] d1,
                             input logic [DIGIT_W-1:0] d2, input logic [DIGIT_W-1:0] d3);
        logic [DIGIT_W-1:0] vals [CODE_LEN];
        int                 k;
        vals = '{d0, d1, d2, d3};
        for (k = 0; k < CODE_LEN; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_CODE_DIGIT_0 + CFG_IDX_W'(k);
            cfg_data <= vals[k];
            @(negedge i_clk);
        end
        // an index past the last digit must be dropped
        cfg_idx  <= CFG_IDX_W'($urandom_range(CODE_LEN, (1 << CFG_IDX_W) - 1));
        cfg_data <= DIGIT_W'($urandom_range((1 << DIGIT_W) - 1));
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] non_digit();
        logic [KEY_W-1:0] v;
        v = 8'($urandom_range(255));
        if (v >= KEY_ZERO && v <= KEY_NINE) v = v ^ 8'h40;
        return v;
    endfunction

    // Return to main, start entry and key in four digits with random noise around them.
    task automatic enter_code(input bit aim);
        logic [KEY_W-1:0] digit;
        int               k;
        send_key(KEY_STAR);
        send_key(KEY_C);
        send_key(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : KEY_NONE);
        for (k = 0; k < CODE_LEN; k++) begin
            while ($urandom_range(3) == 0) send_key(non_digit());
            if (aim && lock_secret[k] >= KEY_ZERO[DIGIT_W-1:0]
                    && lock_secret[k] <= KEY_NINE[DIGIT_W-1:0])
                digit = {2'b00, lock_secret[k]};
            else
                digit = KEY_ZERO + 8'($urandom_range(9));
            send_key(digit);
            send_key(8'($urandom_range(255)));
            while ($urandom_range(2) == 0) send_key(8'($urandom_range(1, 255)));
            send_key(KEY_NONE);
            send_key(8'($urandom_range(255)));
        end
        send_key(8'($urandom_range(255)));
        send_key(8'($urandom_range(255)));
    endtask

    task automatic press_noise();
        int n;
        int k;
        n = $urandom_range(4, 14);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(5))
                0:       send_key(KEY_A);
                1:       send_key(KEY_C);
                2:       send_key(KEY_STAR);
                3:       send_key(KEY_NONE);
                4:       send_key(KEY_ZERO + 8'($urandom_range(9)));
                default: send_key(8'($urandom_range(255)));
            endcase
        end
    endtask

    function automatic logic [DIGIT_W-1:0] any_digit();
        return KEY_ZERO[DIGIT_W-1:0] + DIGIT_W'($urandom_range(9));
    endfunction

    initial begin
        int idle_plan  [4];
        int stall_plan [4];
        int p;
        int r;
        int goal;
        idle_plan  = '{0, 57, 0, 24};
        stall_plan = '{0, 0, 57, 24};
        repeat (9) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < DIR_ROWS; r++)
            send_key(SCAN_TABLE[r].key, SCAN_TABLE[r].known, SCAN_TABLE[r].want);

        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: load_code(KEY_ZERO[DIGIT_W-1:0], KEY_ZERO[DIGIT_W-1:0],
                             KEY_ZERO[DIGIT_W-1:0], KEY_ZERO[DIGIT_W-1:0]);
                1: load_code(KEY_NINE[DIGIT_W-1:0], KEY_NINE[DIGIT_W-1:0],
                             KEY_NINE[DIGIT_W-1:0], KEY_NINE[DIGIT_W-1:0]);
                // the first two values no digit key can match
                3: load_code('0, '1, KEY_ZERO[DIGIT_W-1:0], KEY_NINE[DIGIT_W-1:0]);
                4: load_code(RST_CODE_DIGIT_0, RST_CODE_DIGIT_1,
                             RST_CODE_DIGIT_2, RST_CODE_DIGIT_3);
                default: load_code(any_digit(), any_digit(), any_digit(), any_digit());
            endcase
            send_idle_pct  = idle_plan[p % 4];
            recv_stall_pct = stall_plan[p % 4];
            goal = scans_sent + PHASE_SCANS;
            while (scans_sent < goal) begin
                if ($urandom_range(4) == 0)
                    press_noise();
                else
                    enter_code($urandom_range(1) == 1);
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
hdl/kcl_pkg.sv
hdl/kcl_step.sv
hdl/kcl_out_stage.sv
hdl/keypad_code_lock.sv
tb/keypad_code_lock_test.sv
